FILE: sv/mnrl_pkg.sv
// ----------------------------------------------------------------------------
// mnrl_pkg: shared types and constants of the MIDI note RGB LED controller
// Field widths, opcodes, register indexes and the groups of signals that
// pass between the register bank, the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mnrl_pkg;

   localparam int CHANNEL_W  = 4;
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int LEVEL_W    = 8;
   localparam int TARGET_W   = 3;
   localparam int COLOURS    = 3;
   localparam int ELAPSED_W  = 26;
   localparam int BUILTIN_W  = 21;
   localparam int STRIP_W    = 42;

   localparam int PADDR_W    = 6;
   localparam int CSR_DATA_W = 64;
   localparam int REG_LSB    = 3;

   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);

   localparam int EN_NOTES   = 0;
   localparam int EN_STRIP   = 1;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

   typedef enum logic [1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_TICK     = 2'd2,
      OP_ACTIVITY = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_LISTEN_CHANNEL = 3'd0,
      REG_ENABLE_FLAGS   = 3'd1,
      REG_BRIGHTNESS     = 3'd2,
      REG_IDLE_TIMEOUT   = 3'd3,
      REG_BUILTIN_SLOTS  = 3'd4,
      REG_STRIP_LOW      = 3'd5,
      REG_STRIP_HIGH     = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] listen_channel;
      logic [1:0]           enable_flags;
      logic [LEVEL_W-1:0]   brightness;
      logic [ELAPSED_W-1:0] idle_timeout_ms;
      logic [BUILTIN_W-1:0] builtin_note_slots;
      logic [STRIP_W-1:0]   strip_notes_low;
      logic [STRIP_W-1:0]   strip_notes_high;
   } cfg_type;

   typedef struct packed {
      opcode_type           opcode;
      logic [CHANNEL_W-1:0] event_channel;
      logic [NOTE_W-1:0]    note_number;
      logic [VEL_W-1:0]     velocity;
   } req_type;

   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [LEVEL_W-1:0]  red;
      logic [LEVEL_W-1:0]  green;
      logic [LEVEL_W-1:0]  blue;
      logic                last_update;
   } rsp_type;

endpackage

`default_nettype wire

FILE: sv/mnrl_csr.sv
// ----------------------------------------------------------------------------
// mnrl_csr: configuration register bank
// APB-style slave holding the seven configuration registers, 8-byte spaced.
// ----------------------------------------------------------------------------
`default_nettype none

module mnrl_csr
   import mnrl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [PADDR_W-1:0]    csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[PADDR_W-1:REG_LSB]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_LISTEN_CHANNEL: cfg_in.listen_channel = csr_pwdata[CHANNEL_W-1:0];
            REG_ENABLE_FLAGS:   cfg_in.enable_flags = csr_pwdata[1:0];
            REG_BRIGHTNESS:     cfg_in.brightness = csr_pwdata[LEVEL_W-1:0];
            REG_IDLE_TIMEOUT:   cfg_in.idle_timeout_ms = csr_pwdata[ELAPSED_W-1:0];
            REG_BUILTIN_SLOTS:  cfg_in.builtin_note_slots = csr_pwdata[BUILTIN_W-1:0];
            REG_STRIP_LOW:      cfg_in.strip_notes_low = csr_pwdata[STRIP_W-1:0];
            REG_STRIP_HIGH:     cfg_in.strip_notes_high = csr_pwdata[STRIP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_LISTEN_CHANNEL: csr_prdata = CSR_DATA_W'(cfg_ff.listen_channel);
         REG_ENABLE_FLAGS:   csr_prdata = CSR_DATA_W'(cfg_ff.enable_flags);
         REG_BRIGHTNESS:     csr_prdata = CSR_DATA_W'(cfg_ff.brightness);
         REG_IDLE_TIMEOUT:   csr_prdata = CSR_DATA_W'(cfg_ff.idle_timeout_ms);
         REG_BUILTIN_SLOTS:  csr_prdata = CSR_DATA_W'(cfg_ff.builtin_note_slots);
         REG_STRIP_LOW:      csr_prdata = CSR_DATA_W'(cfg_ff.strip_notes_low);
         REG_STRIP_HIGH:     csr_prdata = CSR_DATA_W'(cfg_ff.strip_notes_high);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.listen_channel     <= '0;
         cfg_ff.enable_flags       <= 2'b11;
         cfg_ff.brightness         <= '1;
         cfg_ff.idle_timeout_ms    <= '0;
         cfg_ff.builtin_note_slots <= '0;
         cfg_ff.strip_notes_low    <= '0;
         cfg_ff.strip_notes_high   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/mnrl_front.sv
// ----------------------------------------------------------------------------
// mnrl_front: item intake and level state
// Accepts items, updates the stored colour levels and the idle counter, and
// hands a snapshot of the levels plus the mask of changed targets onwards.
// ----------------------------------------------------------------------------
`default_nettype none

module mnrl_front
   import mnrl_pkg::*;
#(
   parameter int NT = 5
)
(
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_push,
   input  wire req_type                                req,
   input  wire cfg_type                                cfg,
   input  wire logic                                   q_full,
   output      logic                                   q_push,
   output      logic [NT-1:0]                          q_mask,
   output      logic [NT-1:0][COLOURS-1:0][LEVEL_W-1:0] q_levels
);

   logic [NT-1:0][COLOURS-1:0][LEVEL_W-1:0] lv_ff;
   logic [NT-1:0][COLOURS-1:0][LEVEL_W-1:0] lv_in;
   logic [ELAPSED_W-1:0]                     elapsed_ff;
   logic [ELAPSED_W-1:0]                     elapsed_in;
   logic [ELAPSED_W-1:0]                     elapsed_inc;
   logic                                     done_ff;
   logic                                     done_in;
   logic [NT-1:0][COLOURS-1:0][NOTE_W-1:0]   slot_note;
   logic [NT-1:0]                            slot_ok;
   logic [NT-1:0]                            changed;
   logic [LEVEL_W-1:0]                       level;
   logic                                     accept;
   logic                                     note_hit;
   logic                                     fire;

   assign accept = req_push && !q_full;

   // Note number of every slot; pixel n sits in the low or high word by n/2.
   always_comb begin
      for (int t = 0; t < NT; t++) begin
         for (int c = 0; c < COLOURS; c++) begin
            if (t == 0) begin
               slot_note[t][c] = cfg.builtin_note_slots[NOTE_W*c +: NOTE_W];
            end else if (t - 1 < 2) begin
               slot_note[t][c] =
                  cfg.strip_notes_low[NOTE_W*(((t - 1) & 1)*COLOURS + c) +: NOTE_W];
            end else begin
               slot_note[t][c] =
                  cfg.strip_notes_high[NOTE_W*(((t - 1) & 1)*COLOURS + c) +: NOTE_W];
            end
         end
         slot_ok[t] = (t == 0) || cfg.enable_flags[EN_STRIP];
      end
   end

   // velocity*255/127 equals 2*velocity, plus one only at full velocity.
   assign level = (req.opcode == OP_NOTE_ON) ? {req.velocity, &req.velocity} : '0;
   assign note_hit = cfg.enable_flags[EN_NOTES] &&
                     (req.event_channel == cfg.listen_channel);
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign fire = cfg.enable_flags[EN_NOTES] && (cfg.idle_timeout_ms != '0) &&
                 !done_ff && (elapsed_inc >= cfg.idle_timeout_ms);

   always_comb begin
      lv_in      = lv_ff;
      elapsed_in = elapsed_ff;
      done_in    = done_ff;
      changed    = '0;
      if (accept) begin
         case (req.opcode)
            OP_NOTE_ON, OP_NOTE_OFF: begin
               if (note_hit) begin
                  for (int t = 0; t < NT; t++) begin
                     for (int c = 0; c < COLOURS; c++) begin
                        if (slot_ok[t] && (slot_note[t][c] == req.note_number) &&
                            (lv_ff[t][c] != level)) begin
                           lv_in[t][c] = level;
                           changed[t]  = 1'b1;
                        end
                     end
                  end
               end
            end
            OP_TICK: begin
               elapsed_in = elapsed_inc;
               if (fire) begin
                  done_in = 1'b1;
                  for (int t = 0; t < NT; t++) begin
                     if (slot_ok[t]) begin
                        changed[t] = (lv_ff[t] != '0);
                        lv_in[t]   = '0;
                     end
                  end
               end
            end
            OP_ACTIVITY: begin
               elapsed_in = '0;
               done_in    = 1'b0;
            end
            default: ;
         endcase
      end
   end

   assign q_push   = accept && (changed != '0);
   assign q_mask   = changed;
   assign q_levels = lv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff      <= '0;
         elapsed_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         lv_ff      <= lv_in;
         elapsed_ff <= elapsed_in;
         done_ff    <= done_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/mnrl_back.sv
// ----------------------------------------------------------------------------
// mnrl_back: update queue and result generation
// Holds a short queue of level snapshots and emits one scaled result per
// changed target, lowest target first, into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mnrl_back
   import mnrl_pkg::*;
#(
   parameter int NT = 5
)
(
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   q_push,
   input  wire logic [NT-1:0]                          q_mask,
   input  wire logic [NT-1:0][COLOURS-1:0][LEVEL_W-1:0] q_levels,
   output      logic                                   q_full,
   input  wire logic [LEVEL_W-1:0]                     brightness,
   input  wire logic                                   rsp_pop,
   output      logic                                   rsp_empty,
   output      rsp_type                                rsp
);

   localparam int SEL_W = (NT > 1) ? $clog2(NT) : 1;

   logic [NT-1:0]                           mask_ff   [QDEPTH];
   logic [NT-1:0][COLOURS-1:0][LEVEL_W-1:0] levels_ff [QDEPTH];
   logic [QPTR_W-1:0]                       rd_ptr_ff;
   logic [QPTR_W-1:0]                       wr_ptr_ff;
   logic [QCNT_W-1:0]                       count_ff;
   logic                                    out_valid_ff;
   rsp_type                                 rsp_ff;
   rsp_type                                 rsp_in;

   logic [NT-1:0]                           head_mask;
   logic [NT-1:0]                           sel_onehot;
   logic [NT-1:0]                           rest;
   logic [SEL_W-1:0]                        sel;
   logic [COLOURS-1:0][LEVEL_W-1:0]         head_lv;
   logic                                    advance;
   logic                                    q_pop;

   // level*brightness/255 without a divider, exact for every product of two 8-bit values.
   function automatic logic [LEVEL_W-1:0] scale(input logic [LEVEL_W-1:0] lv,
                                                input logic [LEVEL_W-1:0] b);
      logic [2*LEVEL_W-1:0] p;
      logic [2*LEVEL_W:0]   s;
      p = lv * b;
      s = {1'b0, p} + (2*LEVEL_W+1)'(1) + (2*LEVEL_W+1)'(p[2*LEVEL_W-1:LEVEL_W]);
      return s[2*LEVEL_W-1:LEVEL_W];
   endfunction

   assign q_full    = (count_ff == QCNT_W'(QDEPTH));
   assign head_mask = mask_ff[rd_ptr_ff];
   assign advance   = (count_ff != '0) && (!out_valid_ff || rsp_pop);

   always_comb begin
      sel        = '0;
      sel_onehot = '0;
      for (int i = NT - 1; i >= 0; i--) begin
         if (head_mask[i]) begin
            sel        = SEL_W'(i);
            sel_onehot = NT'(1) << i;
         end
      end
   end

   assign rest    = head_mask & ~sel_onehot;
   assign head_lv = levels_ff[rd_ptr_ff][sel];
   assign q_pop   = advance && (rest == '0);

   always_comb begin
      rsp_in = rsp_ff;
      if (advance) begin
         rsp_in.target      = TARGET_W'(sel);
         rsp_in.red         = scale(head_lv[0], brightness);
         rsp_in.green       = scale(head_lv[1], brightness);
         rsp_in.blue        = scale(head_lv[2], brightness);
         rsp_in.last_update = (rest == '0);
      end
   end

   // Queue storage: push at the write pointer, retire served targets at the head.
   always_ff @(posedge clock) begin
      if (q_push) begin
         mask_ff[wr_ptr_ff]   <= q_mask;
         levels_ff[wr_ptr_ff] <= q_levels;
      end
      if (advance && !q_pop) begin
         mask_ff[rd_ptr_ff] <= rest;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(q_push) - QCNT_W'(q_pop);
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

FILE: sv/midi_note_rgb_led_controller.sv
// ----------------------------------------------------------------------------
// midi_note_rgb_led_controller: MIDI note to RGB LED level controller
// Turns note events, activity notices and millisecond ticks into
// brightness-scaled colour updates for one built-in LED and strip pixels.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Moves
//   req_*     in         req_push / req_full  one event item
//   rsp_*     out        rsp_pop / rsp_empty  one target colour update item
//   csr_*     in/out     APB psel/penable     configuration register access
//
// An input item is taken in every cycle in which the update queue has room.
// An item that changes n targets yields n results, one per cycle while the
// result register is popped; each result scales its three colours together.
// Its first result passes through the queue and then the result register.
// Items that change nothing never enter the queue.
// Reset is synchronous and restores the registers, clears all levels, the
// idle counter and the queue. A stalled result register does not block
// intake until the two-entry queue has filled.
`default_nettype none

module midi_note_rgb_led_controller
   import mnrl_pkg::*;
#(
   parameter int STRIP_PIXELS = 4
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_push,
   output      logic                  req_full,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [CHANNEL_W-1:0]  req_event_channel,
   input  wire logic [NOTE_W-1:0]     req_note_number,
   input  wire logic [VEL_W-1:0]      req_velocity,

   output      logic                  rsp_empty,
   input  wire logic                  rsp_pop,
   output      logic [TARGET_W-1:0]   rsp_target,
   output      logic [LEVEL_W-1:0]    rsp_red,
   output      logic [LEVEL_W-1:0]    rsp_green,
   output      logic [LEVEL_W-1:0]    rsp_blue,
   output      logic                  rsp_last_update,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [PADDR_W-1:0]    csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   // Target 0 is the built-in LED, targets 1 and up are the strip pixels.
   localparam int NT = STRIP_PIXELS + 1;

   cfg_type                                 cfg;
   req_type                                 req;
   rsp_type                                 rsp;
   logic                                    q_full;
   logic                                    q_push;
   logic [NT-1:0]                           q_mask;
   logic [NT-1:0][COLOURS-1:0][LEVEL_W-1:0] q_levels;

   // The input item is gathered into one struct for the front end.
   assign req.opcode        = opcode_type'(req_opcode);
   assign req.event_channel = req_event_channel;
   assign req.note_number   = req_note_number;
   assign req.velocity      = req_velocity;

   // Intake stalls only when the queue between the two halves is full.
   assign req_full = q_full;

   mnrl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The front end owns the level state and decides which targets changed.
   mnrl_front #(.NT(NT)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req      (req),
      .cfg      (cfg),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_mask   (q_mask),
      .q_levels (q_levels)
   );

   // The back end walks each queued snapshot and scales the changed targets.
   mnrl_back #(.NT(NT)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_push     (q_push),
      .q_mask     (q_mask),
      .q_levels   (q_levels),
      .q_full     (q_full),
      .brightness (cfg.brightness),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp        (rsp)
   );

   assign rsp_target      = rsp.target;
   assign rsp_red         = rsp.red;
   assign rsp_green       = rsp.green;
   assign rsp_blue        = rsp.blue;
   assign rsp_last_update = rsp.last_update;

endmodule

`default_nettype wire

FILE: tb/sv/led_update_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_update_checker: colour update predictor and comparator
// Follows the event, result and register channels of the MIDI note RGB LED
// controller, keeps its own copy of the colour levels and registers, and
// compares every colour update item that leaves the block.
// ----------------------------------------------------------------------------

module led_update_checker
   import mnrl_pkg::*;
#(
   parameter int STRIP_PIXELS = 4
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_push,
   input  wire logic                  req_full,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [CHANNEL_W-1:0]  req_event_channel,
   input  wire logic [NOTE_W-1:0]     req_note_number,
   input  wire logic [VEL_W-1:0]      req_velocity,

   input  wire logic                  rsp_empty,
   input  wire logic                  rsp_pop,
   input  wire logic [TARGET_W-1:0]   rsp_target,
   input  wire logic [LEVEL_W-1:0]    rsp_red,
   input  wire logic [LEVEL_W-1:0]    rsp_green,
   input  wire logic [LEVEL_W-1:0]    rsp_blue,
   input  wire logic                  rsp_last_update,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [PADDR_W-1:0]    csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic                  csr_pready,

   output int                         pending_updates,
   output int                         mismatch_total
);

   logic [CHANNEL_W-1:0] listen_channel;
   logic [1:0]           enable_flags;
   logic [LEVEL_W-1:0]   brightness;
   logic [ELAPSED_W-1:0] idle_timeout;
   logic [BUILTIN_W-1:0] builtin_slots;
   logic [STRIP_W-1:0]   strip_low;
   logic [STRIP_W-1:0]   strip_high;

   logic [LEVEL_W-1:0]   builtin_level [COLOURS];
   logic [LEVEL_W-1:0]   pixel_level [4*COLOURS];
   logic [ELAPSED_W-1:0] idle_elapsed;
   logic                 timeout_done;

   rsp_type              expected_updates [$];
   int                   mismatch_count = 0;

   assign mismatch_total = mismatch_count;

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("%0t ns  mismatch: %s", $time, what);
   endtask

   function automatic logic [LEVEL_W-1:0] drive_value(logic [LEVEL_W-1:0] level);
      logic [15:0] product;
      product = level * brightness;
      return LEVEL_W'(product / 16'd255);
   endfunction

   function automatic logic [NOTE_W-1:0] strip_slot_note(int px, int colour);
      logic [STRIP_W-1:0] word;
      word = (px < 2) ? strip_low : strip_high;
      return NOTE_W'(word >> (NOTE_W * ((px % 2) * COLOURS + colour)));
   endfunction

   // One update per changed target, in ascending target order; the last one
   // carries the last_update flag.
   task automatic queue_updates(logic [4:0] changed);
      rsp_type upd;
      int      final_target;
      final_target = -1;
      for (int t = 0; t < 5; t++)
         if (changed[t]) final_target = t;
      for (int t = 0; t < 5; t++) begin
         if (changed[t]) begin
            upd.target = TARGET_W'(t);
            if (t == 0) begin
               upd.red   = drive_value(builtin_level[0]);
               upd.green = drive_value(builtin_level[1]);
               upd.blue  = drive_value(builtin_level[2]);
            end else begin
               upd.red   = drive_value(pixel_level[(t-1)*COLOURS]);
               upd.green = drive_value(pixel_level[(t-1)*COLOURS+1]);
               upd.blue  = drive_value(pixel_level[(t-1)*COLOURS+2]);
            end
            upd.last_update = (t == final_target);
            expected_updates.push_back(upd);
         end
      end
   endtask

   task automatic predict_event(opcode_type op, logic [CHANNEL_W-1:0] chan,
                                logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
      logic [4:0]         changed;
      logic [LEVEL_W-1:0] level;
      changed = '0;
      case (op)
         OP_ACTIVITY: begin
            idle_elapsed = '0;
            timeout_done = 1'b0;
         end
         OP_TICK: begin
            if (idle_elapsed != ELAPSED_MAX) idle_elapsed++;
            if (enable_flags[EN_NOTES] && idle_timeout != '0 && !timeout_done &&
                idle_elapsed >= idle_timeout) begin
               for (int c = 0; c < COLOURS; c++) begin
                  if (builtin_level[c] != '0) changed[0] = 1'b1;
                  builtin_level[c] = '0;
               end
               if (enable_flags[EN_STRIP]) begin
                  for (int px = 0; px < STRIP_PIXELS && px < 4; px++)
                     for (int c = 0; c < COLOURS; c++) begin
                        if (pixel_level[px*COLOURS+c] != '0) changed[px+1] = 1'b1;
                        pixel_level[px*COLOURS+c] = '0;
                     end
               end
               timeout_done = 1'b1;
            end
         end
         default: begin
            if (enable_flags[EN_NOTES] && chan == listen_channel) begin
               level = '0;
               if (op == OP_NOTE_ON && vel != '0)
                  level = LEVEL_W'((int'(vel) * 255) / 127);
               for (int c = 0; c < COLOURS; c++) begin
                  if (builtin_slots[c*NOTE_W +: NOTE_W] == note &&
                      builtin_level[c] != level) begin
                     builtin_level[c] = level;
                     changed[0] = 1'b1;
                  end
               end
               if (enable_flags[EN_STRIP]) begin
                  for (int px = 0; px < STRIP_PIXELS && px < 4; px++)
                     for (int c = 0; c < COLOURS; c++) begin
                        if (strip_slot_note(px, c) == note &&
                            pixel_level[px*COLOURS+c] != level) begin
                           pixel_level[px*COLOURS+c] = level;
                           changed[px+1] = 1'b1;
                        end
                     end
               end
            end
         end
      endcase
      queue_updates(changed);
   endtask

   task automatic write_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_LISTEN_CHANNEL: listen_channel = value[CHANNEL_W-1:0];
         REG_ENABLE_FLAGS:   enable_flags   = value[1:0];
         REG_BRIGHTNESS:     brightness     = value[LEVEL_W-1:0];
         REG_IDLE_TIMEOUT:   idle_timeout   = value[ELAPSED_W-1:0];
         REG_BUILTIN_SLOTS:  builtin_slots  = value[BUILTIN_W-1:0];
         REG_STRIP_LOW:      strip_low      = value[STRIP_W-1:0];
         REG_STRIP_HIGH:     strip_high     = value[STRIP_W-1:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         listen_channel = '0;
         enable_flags   = 2'b11;
         brightness     = 8'd255;
         idle_timeout   = '0;
         builtin_slots  = '0;
         strip_low      = '0;
         strip_high     = '0;
         foreach (builtin_level[i]) builtin_level[i] = '0;
         foreach (pixel_level[i]) pixel_level[i] = '0;
         idle_elapsed   = '0;
         timeout_done   = 1'b0;
         expected_updates.delete();
      end else begin
         // Results first: an update leaving at this edge never belongs to an
         // item that enters at the same edge.
         if (rsp_pop && !rsp_empty) begin
            if (expected_updates.size() == 0) begin
               report_mismatch($sformatf("update for target %0d with none expected",
                                         rsp_target));
            end else begin
               want = expected_updates.pop_front();
               if (rsp_target !== want.target || rsp_red !== want.red ||
                   rsp_green !== want.green || rsp_blue !== want.blue ||
                   rsp_last_update !== want.last_update)
                  report_mismatch($sformatf(
                     "got t%0d rgb %0d/%0d/%0d last %0b, want t%0d rgb %0d/%0d/%0d last %0b",
                     rsp_target, rsp_red, rsp_green, rsp_blue, rsp_last_update,
                     want.target, want.red, want.green, want.blue, want.last_update));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            write_register(reg_index_type'(csr_paddr >> REG_LSB), csr_pwdata);
         if (req_push && !req_full)
            predict_event(opcode_type'(req_opcode), req_event_channel,
                          req_note_number, req_velocity);
      end
      pending_updates <= expected_updates.size();
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: MIDI note RGB LED controller test
// Drives note events, ticks and activity notices through the push/full
// channel, pops colour updates with random stalls, reconfigures the block
// between phases and leaves the checking to the update checker.
// ----------------------------------------------------------------------------

module testbench;
   import mnrl_pkg::*;

   // More than a hundred times the slowest expected run; only a hang reaches it.
   localparam int CYCLE_LIMIT   = 200000;
   // The first update passes through the queue and then the result register;
   // this settle time covers an item that is still in flight but produces nothing.
   localparam int SETTLE_CYCLES = 8;
   localparam int STRIP_COUNT   = 4;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 14;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [1:0]            req_opcode = OP_ACTIVITY;
   logic [CHANNEL_W-1:0]  req_event_channel = '0;
   logic [NOTE_W-1:0]     req_note_number = '0;
   logic [VEL_W-1:0]      req_velocity = '0;

   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [TARGET_W-1:0]   rsp_target;
   logic [LEVEL_W-1:0]    rsp_red;
   logic [LEVEL_W-1:0]    rsp_green;
   logic [LEVEL_W-1:0]    rsp_blue;
   logic                  rsp_last_update;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [PADDR_W-1:0]    csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    pending_updates;
   int                    mismatch_total;
   int                    cycle_count = 0;

   // While steady is set neither side idles: this gives the long stretch of
   // back-to-back items and pops.
   bit                    steady = 1'b0;

   // The channel and note numbers currently configured, so that most random
   // items are note events that actually hit a slot.
   logic [CHANNEL_W-1:0]  active_channel;
   logic [NOTE_W-1:0]     note_pool [6];

   midi_note_rgb_led_controller #(
      .STRIP_PIXELS (STRIP_COUNT)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_opcode        (req_opcode),
      .req_event_channel (req_event_channel),
      .req_note_number   (req_note_number),
      .req_velocity      (req_velocity),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_target        (rsp_target),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_last_update   (rsp_last_update),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   led_update_checker #(
      .STRIP_PIXELS (STRIP_COUNT)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_opcode        (req_opcode),
      .req_event_channel (req_event_channel),
      .req_note_number   (req_note_number),
      .req_velocity      (req_velocity),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_target        (rsp_target),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_last_update   (rsp_last_update),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .pending_updates   (pending_updates),
      .mismatch_total    (mismatch_total)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The result side stalls in about a fifth of the cycles, never while the
   // steady stretch is running.
   always @(posedge clock) begin
      rsp_pop <= steady || ($urandom_range(99) >= 21);
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Offers one item and returns at the edge at which it is accepted. Push
   // stays high afterwards, so back-to-back items need no extra assignment;
   // the random idle cycles come before the item.
   task automatic send_event(opcode_type op, logic [CHANNEL_W-1:0] chan,
                             logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
      while (!steady && $urandom_range(99) < 21) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push          <= 1'b1;
      req_opcode        <= op;
      req_event_channel <= chan;
      req_note_number   <= note;
      req_velocity      <= vel;
      do @(posedge clock); while (req_full);
   endtask

   // Stops pushing and waits until every predicted update has been popped,
   // then lets any item that produces nothing run out of the pipeline.
   task automatic drain_updates();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_updates != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PADDR_W'(idx) << REG_LSB;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Writes the whole register set; only called with the block idle.
   task automatic configure(logic [CHANNEL_W-1:0] chan, logic [1:0] flags,
                            logic [LEVEL_W-1:0] bright, logic [ELAPSED_W-1:0] timeout,
                            logic [BUILTIN_W-1:0] builtin, logic [STRIP_W-1:0] low,
                            logic [STRIP_W-1:0] high);
      write_register(REG_LISTEN_CHANNEL, CSR_DATA_W'(chan));
      write_register(REG_ENABLE_FLAGS,   CSR_DATA_W'(flags));
      write_register(REG_BRIGHTNESS,     CSR_DATA_W'(bright));
      write_register(REG_IDLE_TIMEOUT,   CSR_DATA_W'(timeout));
      write_register(REG_BUILTIN_SLOTS,  CSR_DATA_W'(builtin));
      write_register(REG_STRIP_LOW,      CSR_DATA_W'(low));
      write_register(REG_STRIP_HIGH,     CSR_DATA_W'(high));
      active_channel = chan;
   endtask

   // Fills count slots from the note pool; picks repeat, so duplicate slots
   // turn up naturally.
   function automatic logic [STRIP_W-1:0] pool_slots(int count);
      logic [STRIP_W-1:0] slot_bits;
      slot_bits = '0;
      for (int i = 0; i < count; i++)
         slot_bits[i*NOTE_W +: NOTE_W] = note_pool[$urandom_range(5)];
      return slot_bits;
   endfunction

   // Mostly well-formed note traffic on the listened channel with pool notes,
   // mixed with ticks, activity notices and fully random noise.
   task automatic send_random_event();
      int                 pick;
      logic [VEL_W-1:0]   vel;
      pick = $urandom_range(99);
      vel  = ($urandom_range(9) == 0) ? '0 : VEL_W'($urandom_range(127));
      if (pick < 52)
         send_event(OP_NOTE_ON, active_channel, note_pool[$urandom_range(5)], vel);
      else if (pick < 66)
         send_event(OP_NOTE_OFF, active_channel, note_pool[$urandom_range(5)], vel);
      else if (pick < 80)
         send_event(OP_TICK, CHANNEL_W'($urandom_range(15)), NOTE_W'($urandom_range(127)),
                    VEL_W'($urandom_range(127)));
      else if (pick < 87)
         send_event(OP_ACTIVITY, CHANNEL_W'($urandom_range(15)),
                    NOTE_W'($urandom_range(127)), VEL_W'($urandom_range(127)));
      else
         send_event(opcode_type'($urandom_range(3)), CHANNEL_W'($urandom_range(15)),
                    NOTE_W'($urandom_range(127)), VEL_W'($urandom_range(127)));
   endtask

   initial begin
      logic [1:0]           flags;
      logic [LEVEL_W-1:0]   bright;
      logic [ELAPSED_W-1:0] timeout;
      int                   pick;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Built-in LED on notes 60/61/62; pixel 0 red shares
      // note 60 with the built-in red; pixel 3 uses the extreme notes 0 and
      // 127. Idle timeout of three ticks.
      configure(4'd5, 2'b11, 8'd255, 26'd3,
                {7'd62, 7'd61, 7'd60},
                {7'd68, 7'd67, 7'd66, 7'd65, 7'd64, 7'd60},
                {7'd127, 7'd0, 7'd72, 7'd71, 7'd70, 7'd69});
      send_event(OP_NOTE_ON,  4'd5, 7'd60,  7'd127);  // duplicate slot: two targets
      send_event(OP_NOTE_ON,  4'd5, 7'd60,  7'd127);  // same level again: no update
      send_event(OP_NOTE_ON,  4'd5, 7'd61,  7'd1);
      send_event(OP_NOTE_ON,  4'd5, 7'd127, 7'd64);
      send_event(OP_NOTE_ON,  4'd5, 7'd0,   7'd100);
      send_event(OP_NOTE_OFF, 4'd5, 7'd127, 7'd127);
      send_event(OP_NOTE_ON,  4'd5, 7'd61,  7'd0);    // zero velocity acts as note off
      send_event(OP_NOTE_ON,  4'd4, 7'd62,  7'd127);  // wrong channel
      send_event(OP_NOTE_ON,  4'd5, 7'd66,  7'd127);
      send_event(OP_NOTE_ON,  4'd5, 7'd69,  7'd50);
      send_event(OP_NOTE_ON,  4'd5, 7'd72,  7'd50);
      // Three ticks reach the timeout and clear all five targets at once;
      // the fourth finds the clear already done.
      repeat (4) send_event(OP_TICK, 4'd0, 7'd0, 7'd0);
      send_event(OP_ACTIVITY, 4'd0, 7'd0, 7'd0);
      send_event(OP_NOTE_ON,  4'd5, 7'd67,  7'd90);
      drain_updates();

      // Strip disabled, half brightness, top channel: the idle clear must
      // leave pixel 1 alone.
      configure(4'd15, 2'b01, 8'd128, 26'd1,
                {7'd62, 7'd61, 7'd60},
                {7'd68, 7'd67, 7'd66, 7'd65, 7'd64, 7'd60},
                {7'd127, 7'd0, 7'd72, 7'd71, 7'd70, 7'd69});
      send_event(OP_ACTIVITY, 4'd15, 7'd127, 7'd127);
      send_event(OP_NOTE_ON,  4'd15, 7'd60,  7'd127);
      send_event(OP_NOTE_ON,  4'd0,  7'd61,  7'd127);
      send_event(OP_TICK,     4'd15, 7'd127, 7'd127);
      drain_updates();

      // Note handling off: notes and the timeout do nothing; largest timeout.
      configure(4'd0, 2'b00, 8'd0, 26'h3FFFFFF,
                {7'd62, 7'd61, 7'd60},
                {7'd68, 7'd67, 7'd66, 7'd65, 7'd64, 7'd60},
                {7'd127, 7'd0, 7'd72, 7'd71, 7'd70, 7'd69});
      send_event(OP_NOTE_ON, 4'd0, 7'd60, 7'd127);
      send_event(OP_TICK,    4'd0, 7'd0,  7'd0);
      drain_updates();
      write_register(REG_ENABLE_FLAGS, CSR_DATA_W'(2'b10));
      send_event(OP_NOTE_OFF, 4'd0, 7'd67, 7'd0);
      drain_updates();
      // Zero brightness: levels change but every drive value is zero.
      write_register(REG_ENABLE_FLAGS, CSR_DATA_W'(2'b11));
      send_event(OP_NOTE_ON, 4'd0, 7'd60, 7'd127);
      drain_updates();

      // Random phases, each with fresh registers and a fresh note pool.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         foreach (note_pool[i]) note_pool[i] = NOTE_W'($urandom_range(127));
         flags = ($urandom_range(9) < 7) ? 2'b11 : 2'($urandom_range(3));
         pick  = $urandom_range(2);
         bright = (pick == 0) ? 8'd255 : (pick == 1) ? 8'($urandom_range(255)) : 8'd1;
         if (phase == 1)
            timeout = 26'h3FFFFFF;
         else if ($urandom_range(3) == 0)
            timeout = '0;
         else
            timeout = ELAPSED_W'($urandom_range(1, 6));
         configure(CHANNEL_W'($urandom_range(15)), flags, bright, timeout,
                   BUILTIN_W'(pool_slots(3)), pool_slots(6), pool_slots(6));
         steady = (phase == 3);
         repeat (PHASE_ITEMS) send_random_event();
         drain_updates();
         steady = 1'b0;
      end

      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_total == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
